FILE: rtl/histogram_equalizer_top_assert.svh
// Assertion macros for the histogram equalizer top level.
// Depends on signals named clk and rst_n in the module that includes it.
`ifndef HISTOGRAM_EQUALIZER_TOP_ASSERT_SVH
`define HISTOGRAM_EQUALIZER_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define HEQ_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define HEQ_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/heq_pkg.sv
// Shared constants, types and codes of the histogram equalizer.
// No dependencies; the divider, top and sim files import it.
`timescale 1ns / 1ps

package heq_pkg;

    localparam int LEVELS     = 256;
    localparam int COUNT_BITS = 18;
    localparam int IDX_BITS   = $clog2(LEVELS);
    localparam int MAP_BITS   = 8;
    localparam int CUM_BITS   = COUNT_BITS + IDX_BITS;
    localparam int NUM_BITS   = CUM_BITS + MAP_BITS;
    localparam int STEP_BITS  = $clog2(MAP_BITS);

    localparam logic [IDX_BITS-1:0]   LAST_IDX  = IDX_BITS'(LEVELS - 1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [MAP_BITS-1:0]   MAX_LEVEL = {MAP_BITS{1'b1}};

    typedef enum logic [1:0] {
        MODE_CLEAR,
        MODE_COUNT,
        MODE_BUILD,
        MODE_MAP
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_ACCUM,
        ST_DIVIDE,
        ST_WAIT
    } state_t;

    typedef struct packed {
        logic                  start;
        logic [NUM_BITS-1:0]   num;
        logic [COUNT_BITS-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic                done;
        logic [MAP_BITS-1:0] quot;
    } div_rsp_t;

endpackage

FILE: rtl/heq_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
`timescale 1ns / 1ps

module heq_ram #(
    parameter int DATA_BITS = 8,
    parameter int ADDR_BITS = 8
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [DATA_BITS-1:0] wr_data,
    input  logic                 rd_en,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [DATA_BITS-1:0] rd_data
);

    localparam int DEPTH = 1 << ADDR_BITS;

    logic [DATA_BITS-1:0] mem [DEPTH];
    logic [DATA_BITS-1:0] rd_data_reg;

    // A read of the address being written returns the old contents.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/heq_div.sv
// Restoring divider for floor(num / den), one quotient bit per cycle,
// saturated at the top map level and forced to zero for a zero divisor. Uses heq_pkg.
`timescale 1ns / 1ps

module heq_div (
    input  logic               clk,
    input  logic               rst_n,
    input  heq_pkg::div_req_t  req,
    output heq_pkg::div_rsp_t  rsp
);

    import heq_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [STEP_BITS-1:0] step_reg;
    logic [NUM_BITS-1:0]  rem_reg;
    logic [NUM_BITS-1:0]  dsh_reg;
    logic [MAP_BITS-1:0]  quot_reg;
    logic                 zero_reg;
    logic                 sat_reg;
    logic                 fits;

    assign fits = rem_reg >= dsh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_BITS'(MAP_BITS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // A quotient that does not fit in the map width saturates, so only
    // MAP_BITS quotient bits are ever developed.
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg  <= req.num;
            dsh_reg  <= NUM_BITS'(req.den) << (MAP_BITS - 1);
            quot_reg <= '0;
            zero_reg <= (req.den == '0);
            sat_reg  <= (req.num >= (NUM_BITS'(req.den) << MAP_BITS));
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_reg <= rem_reg - dsh_reg;
            end
            dsh_reg  <= dsh_reg >> 1;
            quot_reg <= {quot_reg[MAP_BITS-2:0], fits};
        end
    end

    always_comb
    begin
        rsp.done = done_reg;
        if (zero_reg)
        begin
            rsp.quot = '0;
        end
        else if (sat_reg)
        begin
            rsp.quot = MAX_LEVEL;
        end
        else
        begin
            rsp.quot = quot_reg;
        end
    end

endmodule

FILE: rtl/histogram_equalizer_top.sv
// A map word goes through the map RAM read register into the output queue.
// Throughput: count, clear and map take one word per cycle while idle and the
// output queue has room. Build walks all bins, each through the read, accumulate,
// divide and wait steps of the one-bit-per-cycle divider, with input held off.
// Reset clears the histogram at once through per-bin valid bits; the level map
// is not cleared and holds nothing meaningful until the first build.
`timescale 1ns / 1ps

module histogram_equalizer_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] pixel
    input  logic [1:0] s_axis_tuser,   // [1:0] mode
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata    // [7:0] mapped_pixel
);

    import heq_pkg::*;

    state_t                state_reg, state_next;
    mode_t                 mode;
    logic                  accept;
    logic [IDX_BITS-1:0]   pix_idx;

    // Histogram memory and its valid bits.
    logic [LEVELS-1:0]     bin_vld_reg;
    logic                  bin_re;
    logic [IDX_BITS-1:0]   bin_raddr;
    logic [COUNT_BITS-1:0] bin_rdata;
    logic                  bin_we;
    logic [COUNT_BITS-1:0] bin_wdata;
    logic [COUNT_BITS-1:0] bin_eff;
    logic                  rd_vld_reg;
    logic                  fwd_hit_reg;
    logic [COUNT_BITS-1:0] fwd_data_reg;
    logic [COUNT_BITS-1:0] total_reg;

    // Second stage of count and map words.
    logic                  s1_count_reg;
    logic                  s1_map_reg;
    logic [IDX_BITS-1:0]   s1_idx_reg;

    // Level map memory.
    logic                  map_re;
    logic                  map_we;
    logic [MAP_BITS-1:0]   map_rdata;

    // Build walk.
    logic [IDX_BITS-1:0]   walk_idx_reg;
    logic [CUM_BITS-1:0]   cum_reg;
    div_req_t              div_req;
    div_rsp_t              div_rsp;

    // Two-entry output queue.
    logic [1:0]            out_cnt_reg;
    logic [MAP_BITS-1:0]   head_reg;
    logic [MAP_BITS-1:0]   skid_reg;
    logic                  pop;
    logic                  push;
    logic                  out_room;

    assign mode    = mode_t'(s_axis_tuser);
    assign accept  = s_axis_tvalid && s_axis_tready;
    assign pix_idx = ({1'b0, s_axis_tdata} > 9'(LEVELS - 1)) ? LAST_IDX
                                                            : s_axis_tdata[IDX_BITS-1:0];

    assign pop  = m_axis_tvalid && m_axis_tready;
    assign push = s1_map_reg;

    // Take a word only if a map result issued now still finds a queue slot.
    always_comb
    begin
        case (out_cnt_reg)
            2'd0:    out_room = 1'b1;
            2'd1:    out_room = pop || !push;
            2'd2:    out_room = pop && !push;
            default: out_room = 1'b0;
        endcase
    end

    assign s_axis_tready = (state_reg == ST_IDLE) && out_room;

    // ------------------------------------------------------------------
    // Control: walk state machine and memory port selection.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        bin_re      = 1'b0;
        bin_raddr   = walk_idx_reg;
        map_we      = 1'b0;
        div_req.start = 1'b0;
        div_req.num = (NUM_BITS'(cum_reg) << MAP_BITS) - NUM_BITS'(cum_reg);
        div_req.den = total_reg;
        case (state_reg)
            ST_IDLE:
            begin
                bin_re    = accept && (mode == MODE_COUNT);
                bin_raddr = pix_idx;
                if (accept && (mode == MODE_BUILD))
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                bin_re     = 1'b1;
                state_next = ST_ACCUM;
            end
            ST_ACCUM:
            begin
                state_next = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                div_req.start = 1'b1;
                state_next    = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (div_rsp.done)
                begin
                    map_we     = 1'b1;
                    state_next = (walk_idx_reg == LAST_IDX) ? ST_IDLE : ST_READ;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE)
        begin
            walk_idx_reg <= '0;
            cum_reg      <= '0;
        end
        else
        begin
            if (state_reg == ST_ACCUM)
            begin
                cum_reg <= cum_reg + CUM_BITS'(bin_eff);
            end
            if (map_we)
            begin
                walk_idx_reg <= walk_idx_reg + 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Histogram read-modify-write.
    // ------------------------------------------------------------------
    assign bin_we    = s1_count_reg;
    assign bin_eff   = fwd_hit_reg ? fwd_data_reg : (rd_vld_reg ? bin_rdata : '0);
    assign bin_wdata = (bin_eff == COUNT_MAX) ? bin_eff : bin_eff + 1'b1;

    heq_ram #(
        .DATA_BITS (COUNT_BITS),
        .ADDR_BITS (IDX_BITS)
    ) u_bin_ram (
        .clk     (clk),
        .wr_en   (bin_we),
        .wr_addr (s1_idx_reg),
        .wr_data (bin_wdata),
        .rd_en   (bin_re),
        .rd_addr (bin_raddr),
        .rd_data (bin_rdata)
    );

    // A clear drops every valid bit at once and wins over a write in flight.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_vld_reg  <= '0;
            rd_vld_reg   <= 1'b0;
            fwd_hit_reg  <= 1'b0;
            total_reg    <= '0;
            s1_count_reg <= 1'b0;
            s1_map_reg   <= 1'b0;
        end
        else
        begin
            if (accept && (mode == MODE_CLEAR))
            begin
                bin_vld_reg <= '0;
                total_reg   <= '0;
            end
            else
            begin
                if (bin_we)
                begin
                    bin_vld_reg[s1_idx_reg] <= 1'b1;
                end
                if (accept && (mode == MODE_COUNT) && (total_reg != COUNT_MAX))
                begin
                    total_reg <= total_reg + 1'b1;
                end
            end
            if (bin_re)
            begin
                rd_vld_reg <= bin_vld_reg[bin_raddr];
            end
            // The memory returns stale data when the bin read now is the
            // one being written back at the same edge.
            fwd_hit_reg  <= bin_we && bin_re && (s1_idx_reg == bin_raddr);
            s1_count_reg <= accept && (mode == MODE_COUNT);
            s1_map_reg   <= map_re;
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_data_reg <= bin_wdata;
        s1_idx_reg   <= pix_idx;
    end

    // ------------------------------------------------------------------
    // Level map and divider.
    // ------------------------------------------------------------------
    assign map_re = accept && (mode == MODE_MAP);

    heq_ram #(
        .DATA_BITS (MAP_BITS),
        .ADDR_BITS (IDX_BITS)
    ) u_map_ram (
        .clk     (clk),
        .wr_en   (map_we),
        .wr_addr (walk_idx_reg),
        .wr_data (div_rsp.quot),
        .rd_en   (map_re),
        .rd_addr (pix_idx),
        .rd_data (map_rdata)
    );

    heq_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // ------------------------------------------------------------------
    // Output queue.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_cnt_reg <= '0;
        end
        else
        begin
            out_cnt_reg <= out_cnt_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop || (out_cnt_reg == 2'd0))
        begin
            head_reg <= (out_cnt_reg == 2'd2) ? skid_reg : map_rdata;
        end
        if (push && (((out_cnt_reg == 2'd1) && !pop) || ((out_cnt_reg == 2'd2) && pop)))
        begin
            skid_reg <= map_rdata;
        end
    end

    assign m_axis_tvalid = (out_cnt_reg != 2'd0);
    assign m_axis_tdata  = head_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    `include "histogram_equalizer_top_assert.svh"

    `HEQ_ASSERT_IMP(a_queue_bound, 1'b1, out_cnt_reg != 2'd3, "output queue overflow")
    `HEQ_ASSERT_IMP(a_ready_idle, s_axis_tready, state_reg == ST_IDLE, "word taken during walk")
    `HEQ_ASSERT_IMP(a_div_done, div_rsp.done, state_reg == ST_WAIT, "divider result unexpected")
    `HEQ_ASSERT_NXT(a_build_start, accept && (mode == MODE_BUILD),
        (state_reg == ST_READ) && (walk_idx_reg == '0), "build walk did not start")

endmodule

FILE: sim/heq_level_checker.sv
// Checker for the histogram equalizer: watches both stream channels, keeps its
// own histogram and level map, and compares every mapped word in order.
// Depends on heq_pkg for the mode codes and the table sizes.
`timescale 1ns / 1ps

module heq_level_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    input  logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,
    input  logic [1:0] s_axis_tuser,
    input  logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    input  logic [7:0] m_axis_tdata,
    output int         mismatch_count,
    output int         outstanding
);

    import heq_pkg::*;

    logic [COUNT_BITS-1:0] bin_tally [LEVELS];
    logic [COUNT_BITS-1:0] pixel_sum;
    logic [MAP_BITS-1:0]   level_lut [LEVELS];
    logic [MAP_BITS-1:0]   expected_levels [$];
    logic [IDX_BITS-1:0]   bin_idx;
    logic [MAP_BITS-1:0]   want;

    task automatic report_mismatch(input string what);
        $display("%0t ns: %s", $time, what);
        mismatch_count++;
    endtask

    function automatic logic [COUNT_BITS-1:0] bump(input logic [COUNT_BITS-1:0] v);
        return (v == COUNT_MAX) ? v : v + 1'b1;
    endfunction

    // Cumulative walk over the bins; a sum past a saturated total clips at the top level.
    function automatic void rebuild_level_lut();
        logic [CUM_BITS-1:0] running;
        logic [NUM_BITS-1:0] scaled;
        logic [NUM_BITS-1:0] quot;
        running = '0;
        for (int i = 0; i < LEVELS; i++)
        begin
            running = running + CUM_BITS'(bin_tally[i]);
            quot = '0;
            if (pixel_sum != '0)
            begin
                scaled = NUM_BITS'(running) * NUM_BITS'(MAX_LEVEL);
                quot = scaled / NUM_BITS'(pixel_sum);
                if (quot > NUM_BITS'(MAX_LEVEL))
                    quot = NUM_BITS'(MAX_LEVEL);
            end
            level_lut[i] = quot[MAP_BITS-1:0];
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LEVELS; i++)
                bin_tally[i] = '0;
            pixel_sum = '0;
            expected_levels.delete();
            mismatch_count = 0;
            outstanding <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_levels.size() == 0)
                    report_mismatch($sformatf("unexpected word, mapped_pixel %0d",
                                              m_axis_tdata));
                else
                begin
                    want = expected_levels.pop_front();
                    if (m_axis_tdata !== want)
                        report_mismatch($sformatf("mapped_pixel %0d, expected %0d",
                                                  m_axis_tdata, want));
                end
            end

            if (s_axis_tvalid && s_axis_tready)
            begin
                bin_idx = (int'(s_axis_tdata) >= LEVELS) ? LAST_IDX
                                                         : IDX_BITS'(s_axis_tdata);
                case (mode_t'(s_axis_tuser))
                    MODE_CLEAR:
                    begin
                        for (int i = 0; i < LEVELS; i++)
                            bin_tally[i] = '0;
                        pixel_sum = '0;
                    end
                    MODE_COUNT:
                    begin
                        bin_tally[bin_idx] = bump(bin_tally[bin_idx]);
                        pixel_sum = bump(pixel_sum);
                    end
                    MODE_BUILD:
                        rebuild_level_lut();
                    default:
                        expected_levels.push_back(level_lut[bin_idx]);
                endcase
            end

            outstanding <= expected_levels.size();
        end
    end

endmodule

FILE: sim/tb_histogram_equalizer_top.sv
// Testbench top for the histogram equalizer: clock, reset, stimulus, receiver
// stalls and the verdict. Depends on heq_pkg, the block and heq_level_checker.
`timescale 1ns / 1ps

module tb_histogram_equalizer_top;
    import heq_pkg::*;

    localparam int RANDOM_WORDS = 1220;
    localparam int HOLD_CYCLES  = 300;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = '0;   // [7:0] pixel
    logic [1:0] s_axis_tuser = '0;   // [1:0] mode
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;        // [7:0] mapped_pixel

    int mismatch_count;
    int outstanding;

    int words_sent = 0;
    int burst_left = 0;
    bit gapless = 1'b0;
    bit hold_off_req = 1'b0;
    int ready_pct = 100;
    int phase_left = 0;
    int random_start;

    histogram_equalizer_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    heq_level_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    always #1 clk = ~clk;

    initial
    begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // Receiver: phases of different readiness, plus one long hold-off on request.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_off_req = 1'b0;
            end
            else
            begin
                if (phase_left == 0)
                begin
                    case ($urandom_range(0, 3))
                        0: ready_pct = 100;
                        1: ready_pct = 50;
                        2: ready_pct = 15;
                        default: ready_pct = 85;
                    endcase
                    phase_left = $urandom_range(32, 300);
                end
                phase_left--;
                m_axis_tready <= ($urandom_range(1, 100) <= ready_pct);
            end
        end
    end

    task automatic send_word(input mode_t mode, input logic [7:0] pixel);
        int gap;
        if (burst_left == 0)
        begin
            gap = (gapless || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 32);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pixel;
        s_axis_tuser  <= mode;
        do
            @(posedge clk);
        while (!s_axis_tready);
        burst_left--;
        words_sent++;
    endtask

    // Stop offering words and wait until every mapped word has come back.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    function automatic logic [7:0] pick_pixel(input int style, input logic [7:0] base);
        case (style)
            0: return 8'($urandom_range(0, 255));
            1: return base + 8'($urandom_range(0, 15));
            2: return $urandom_range(0, 1) ? base + 8'($urandom_range(0, 3))
                                           : ~base - 8'($urandom_range(0, 3));
            default:
                case ($urandom_range(0, 3))
                    0: return 8'h00;
                    1: return 8'h01;
                    2: return 8'hFE;
                    default: return 8'hFF;
                endcase
        endcase
    endfunction

    // One image: optional clear, random-shape histogram, build, lookups, optional drain.
    task automatic run_frame();
        int style;
        int n_counts;
        int n_maps;
        logic [7:0] base;
        style = $urandom_range(0, 3);
        base = 8'($urandom_range(0, 255));
        n_counts = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 60);
        n_maps = $urandom_range(4, 40);
        if ($urandom_range(0, 3) != 0)
            send_word(MODE_CLEAR, 8'($urandom_range(0, 255)));
        for (int i = 0; i < n_counts; i++)
            send_word(MODE_COUNT, pick_pixel(style, base));
        send_word(MODE_BUILD, 8'($urandom_range(0, 255)));
        for (int i = 0; i < n_maps; i++)
            send_word(MODE_MAP, $urandom_range(0, 1) ? pick_pixel(style, base)
                                                     : pick_pixel(0, base));
        if ($urandom_range(0, 3) == 0)
            drain();
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Build on an empty histogram first, so no lookup ever hits an unwritten entry.
        send_word(MODE_BUILD, 8'h00);
        send_word(MODE_MAP, 8'h00);
        send_word(MODE_MAP, 8'hFF);
        send_word(MODE_COUNT, 8'h00);
        send_word(MODE_COUNT, 8'hFF);
        send_word(MODE_COUNT, 8'h80);
        send_word(MODE_COUNT, 8'h80);
        send_word(MODE_COUNT, 8'hAA);
        send_word(MODE_COUNT, 8'h55);
        send_word(MODE_BUILD, 8'hFF);
        send_word(MODE_MAP, 8'h00);
        send_word(MODE_MAP, 8'hFF);
        send_word(MODE_MAP, 8'h80);
        send_word(MODE_MAP, 8'h7F);
        send_word(MODE_MAP, 8'hAA);
        send_word(MODE_MAP, 8'h55);
        send_word(MODE_MAP, 8'h01);
        // A clear leaves the level map alone until the next build.
        send_word(MODE_CLEAR, 8'h00);
        send_word(MODE_MAP, 8'h80);
        send_word(MODE_BUILD, 8'h00);
        send_word(MODE_MAP, 8'h80);
        send_word(MODE_MAP, 8'hFF);
        drain();

        // One heavy bin beside a light one, counted back to back on the same bin.
        gapless = 1'b1;
        send_word(MODE_CLEAR, 8'h00);
        for (int k = 0; k < 60; k++)
            send_word(MODE_COUNT, 8'd200);
        repeat (4) send_word(MODE_COUNT, 8'd3);
        send_word(MODE_BUILD, 8'h00);
        send_word(MODE_MAP, 8'd0);
        send_word(MODE_MAP, 8'd3);
        send_word(MODE_MAP, 8'd199);
        send_word(MODE_MAP, 8'd200);
        send_word(MODE_MAP, 8'd255);
        drain();

        // Long receiver hold-off while lookups keep coming, so the input backs up.
        hold_off_req = 1'b1;
        for (int k = 0; k < 40; k++)
            send_word(MODE_MAP, 8'($urandom_range(0, 255)));
        gapless = 1'b0;
        drain();

        random_start = words_sent;
        while (words_sent - random_start < RANDOM_WORDS)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                // Stray words in any mode, outside a well-formed frame.
                repeat ($urandom_range(1, 5))
                    send_word(mode_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
            end
            else
                run_frame();
        end

        drain();
        repeat (40) @(posedge clk);
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
